// ===== design/wmpa_pkg.sv =====
// ----------------------------------------------------------------------------
// wmpa_pkg
// Shared types and constants for the windowed masked point average core.
// ----------------------------------------------------------------------------
`default_nettype none

package wmpa_pkg;

  localparam int unsigned REG_W      = 11;
  localparam int unsigned COORD_W    = 22;
  localparam int unsigned SUM_W      = 43;
  localparam int unsigned CNT_W      = 21;
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned STEP_W     = 6;
  localparam int unsigned DIV_STEPS  = SUM_W;

  localparam int unsigned FRAME_WIDTH  = 1920;
  localparam int unsigned FRAME_HEIGHT = 1080;
  localparam int unsigned DIM_W        = 13;

  localparam logic [REG_W-1:0] WIN_LEFT_RST   = 11'd350;
  localparam logic [REG_W-1:0] WIN_TOP_RST    = 11'd200;
  localparam logic [REG_W-1:0] WIN_RIGHT_RST  = 11'd400;
  localparam logic [REG_W-1:0] WIN_BOTTOM_RST = 11'd250;

  localparam logic [CNT_W-1:0]   COUNT_MAX     = 21'h1F_FFFF;
  localparam logic [COORD_W-1:0] MINUS_ONE_Q16 = 22'h3F_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIN_LEFT   = 2'd0,
    REG_WIN_TOP    = 2'd1,
    REG_WIN_RIGHT  = 2'd2,
    REG_WIN_BOTTOM = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ===== design/window_masked_point_average_core.sv =====
// ----------------------------------------------------------------------------
// window_masked_point_average_core
// Sums X, Y, Z of valid points inside a window and reports the means per frame.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                    | tuser      | tlast
//  in_     | in  | col, row, coord_x, coord_y, coord_z   | non_finite | frame_end
//  out_    | out | avg_x, avg_y, avg_z, zero pad to 72   | found      | -
//  cfg_    | in  | plain write: cfg_we, cfg_index, cfg_data (no handshake)
//
//  Points without tlast are taken back to back while the core is idle. A tlast
//  beat with points counted starts the division (one restoring divider, one
//  quotient bit a cycle, shared by X, Y and Z), then the output register loads.
//  in_tready is low while the divider runs and while the means wait to load.
//  rst_n is synchronous; it restores the window defaults and clears the sums.
// ----------------------------------------------------------------------------
`default_nettype none

module window_masked_point_average_core (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [wmpa_pkg::IN_DATA_W-1:0]       in_tdata,  // col, row, coord_x, coord_y, coord_z
  input  wire                                  in_tuser,  // non_finite
  input  wire                                  in_tlast,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [wmpa_pkg::OUT_DATA_W-1:0]      out_tdata, // avg_x, avg_y, avg_z, pad
  output logic                                 out_tuser, // found
  input  wire                                  cfg_we,
  input  wire  [wmpa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [wmpa_pkg::REG_W-1:0]           cfg_data
);

  localparam int unsigned CW = wmpa_pkg::COORD_W;
  localparam int unsigned SW = wmpa_pkg::SUM_W;
  localparam int unsigned NW = wmpa_pkg::CNT_W;
  localparam int unsigned RW = wmpa_pkg::REG_W;
  localparam int unsigned TW = wmpa_pkg::STEP_W;

  wmpa_pkg::state_t state_r, state_nxt;

  logic [RW-1:0] win_left_r, win_top_r, win_right_r, win_bottom_r;

  logic signed [SW-1:0] sum_x_r, sum_y_r, sum_z_r;
  logic signed [SW-1:0] sum_x_nxt, sum_y_nxt, sum_z_nxt;
  logic [NW-1:0]        cnt_r, cnt_nxt;

  logic [1:0]    sel_r, sel_nxt;
  logic [TW-1:0] step_r, step_nxt;
  logic [SW-1:0] dvd_r, dvd_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic          neg_r, neg_nxt;

  logic [CW-1:0] res_r [3];
  logic [CW-1:0] res_nxt [3];
  logic          found_r, found_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [3*CW-1:0] out_data_r;
  logic          out_found_r;
  logic          out_load;

  logic [RW-1:0]        pt_col, pt_row;
  logic signed [CW-1:0] pt_x, pt_y, pt_z;
  logic                 in_acc, pt_inside, pt_good, pt_add;

  logic signed [SW-1:0] sel_sum;
  logic [NW:0]          rem_sh;
  logic [NW+1:0]        diff;
  logic                 ge;
  logic [CW-1:0]        quo;

  assign pt_col = in_tdata[RW-1:0];
  assign pt_row = in_tdata[2*RW-1:RW];
  assign pt_x   = in_tdata[2*RW+CW-1:2*RW];
  assign pt_y   = in_tdata[2*RW+2*CW-1:2*RW+CW];
  assign pt_z   = in_tdata[2*RW+3*CW-1:2*RW+2*CW];

  assign in_tready = (state_r == wmpa_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign pt_inside = (pt_col >= win_left_r) && (pt_col < win_right_r) &&
                     (pt_row >= win_top_r) && (pt_row < win_bottom_r) &&
                     ({2'b00, pt_col} < wmpa_pkg::DIM_W'(wmpa_pkg::FRAME_WIDTH)) &&
                     ({2'b00, pt_row} < wmpa_pkg::DIM_W'(wmpa_pkg::FRAME_HEIGHT));
  assign pt_good   = pt_inside && !in_tuser && (pt_x != '0) && (pt_y != '0) &&
                     (pt_z != '0);
  assign pt_add    = pt_good && (cnt_r != wmpa_pkg::COUNT_MAX);

  // shared divider datapath
  always_comb begin
    case (sel_r)
      2'd0:    sel_sum = sum_x_r;
      2'd1:    sel_sum = sum_y_r;
      default: sel_sum = sum_z_r;
    endcase
  end

  assign rem_sh = {rem_r, dvd_r[SW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, cnt_r};
  assign ge     = !diff[NW+1];
  assign quo    = {dvd_r[CW-2:0], ge};

  assign out_load = (state_r == wmpa_pkg::ST_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    sum_x_nxt     = sum_x_r;
    sum_y_nxt     = sum_y_r;
    sum_z_nxt     = sum_z_r;
    cnt_nxt       = cnt_r;
    sel_nxt       = sel_r;
    step_nxt      = step_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    res_nxt       = res_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_tready;

    case (state_r)
      wmpa_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (pt_add) begin
            sum_x_nxt = sum_x_r + SW'(pt_x);
            sum_y_nxt = sum_y_r + SW'(pt_y);
            sum_z_nxt = sum_z_r + SW'(pt_z);
            cnt_nxt   = cnt_r + NW'(1);
          end
          if (in_tlast) begin
            sel_nxt = 2'd0;
            if (pt_add || (cnt_r != '0)) begin
              found_nxt = 1'b1;
              state_nxt = wmpa_pkg::ST_SETUP;
            end else begin
              found_nxt  = 1'b0;
              res_nxt[0] = wmpa_pkg::MINUS_ONE_Q16;
              res_nxt[1] = wmpa_pkg::MINUS_ONE_Q16;
              res_nxt[2] = wmpa_pkg::MINUS_ONE_Q16;
              state_nxt  = wmpa_pkg::ST_OUT;
            end
          end
        end
      end
      wmpa_pkg::ST_SETUP: begin
        neg_nxt   = sel_sum[SW-1];
        dvd_nxt   = sel_sum[SW-1] ? SW'(-sel_sum) : SW'(sel_sum);
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = wmpa_pkg::ST_DIV;
      end
      wmpa_pkg::ST_DIV: begin
        rem_nxt  = ge ? diff[NW-1:0] : rem_sh[NW-1:0];
        dvd_nxt  = {dvd_r[SW-2:0], ge};
        step_nxt = step_r + TW'(1);
        if (step_r == TW'(wmpa_pkg::DIV_STEPS - 1)) begin
          res_nxt[sel_r] = neg_r ? CW'(-quo) : quo;
          if (sel_r == 2'd2) begin
            state_nxt = wmpa_pkg::ST_OUT;
          end else begin
            sel_nxt   = sel_r + 2'd1;
            state_nxt = wmpa_pkg::ST_SETUP;
          end
        end
      end
      wmpa_pkg::ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          sum_x_nxt     = '0;
          sum_y_nxt     = '0;
          sum_z_nxt     = '0;
          cnt_nxt       = '0;
          state_nxt     = wmpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wmpa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wmpa_pkg::ST_IDLE;
      win_left_r   <= wmpa_pkg::WIN_LEFT_RST;
      win_top_r    <= wmpa_pkg::WIN_TOP_RST;
      win_right_r  <= wmpa_pkg::WIN_RIGHT_RST;
      win_bottom_r <= wmpa_pkg::WIN_BOTTOM_RST;
      sum_x_r      <= '0;
      sum_y_r      <= '0;
      sum_z_r      <= '0;
      cnt_r        <= '0;
      sel_r        <= '0;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
      sum_z_r     <= sum_z_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (wmpa_pkg::reg_idx_t'(cfg_index))
          wmpa_pkg::REG_WIN_LEFT:   win_left_r   <= cfg_data;
          wmpa_pkg::REG_WIN_TOP:    win_top_r    <= cfg_data;
          wmpa_pkg::REG_WIN_RIGHT:  win_right_r  <= cfg_data;
          wmpa_pkg::REG_WIN_BOTTOM: win_bottom_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r   <= dvd_nxt;
    rem_r   <= rem_nxt;
    neg_r   <= neg_nxt;
    res_r   <= res_nxt;
    found_r <= found_nxt;
    if (out_load) begin
      out_data_r  <= {res_r[2], res_r[1], res_r[0]};
      out_found_r <= found_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(wmpa_pkg::OUT_DATA_W - 3*CW)'(0), out_data_r};
  assign out_tuser  = out_found_r;

endmodule

`default_nettype wire
